/* hw/rtl/rbr_pkg.sv */
// Shared types and constants for the reconnect backoff rotator.
`timescale 1ns / 1ps
`default_nettype none

package rbr_pkg;

    localparam int SLOT_COUNT    = 4;
    localparam int MASK_W        = 4;
    localparam int DELAY_W       = 31;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int SLOT_W        = 2;
    localparam int CFG_ADDR_W    = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [MASK_W-1:0] PRESENT_MASK =
        (SLOT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SLOT_COUNT) - 1);

    localparam logic [MASK_W-1:0]  SLOT_MASK_RST = '0;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = DELAY_W'(5000);
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(300000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SLOT_MASK = 2'd0,
        REG_MIN_DELAY = 2'd1,
        REG_MAX_DELAY = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic commit;
    } rbr_cmd_t;

    typedef struct packed {
        logic out_valid;
    } rbr_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/reconnect_backoff_rotator.sv */
// Top level of the reconnect backoff rotator.
//
// Each input item is one tick: enable flag, link-up flag and a wrapping
// millisecond time. Each tick produces exactly one result item that reports
// a link change, the recorded link state, and whether a reconnect attempt
// starts, on which credential slot, or that no slot holds credentials.
// Configuration is to be written by the user through cfg_we, cfg_addr and
// cfg_wdata only while the block is idle, which the block does not enforce:
// index 0 is the slot mask, 1 the minimum and 2 the maximum retry delay in milliseconds.
// An item is captured at acceptance, evaluated (elapsed time, slot pick,
// doubled delay) in S_EVAL, and the state update then loads the result
// register in S_COMMIT. The controller handles one item at a time, so it
// takes no new item until the previous one has been committed.
// A new item is accepted while the previous result still waits in the
// result register; if the receiver stalls, the update step waits until that
// register empties, and s_tready stays low meanwhile.
// Reset clears the backoff state, loads the configuration defaults and
// empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module reconnect_backoff_rotator #(
    parameter int SLOT_COUNT = rbr_pkg::SLOT_COUNT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [rbr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [rbr_pkg::DELAY_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: enabled, link_up, now_ms[31:0], zero padding.
    input  wire logic [rbr_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: link_changed, link_state, attempt_started,
    // attempt_slot[1:0], no_credentials, zero padding.
    output logic [rbr_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import rbr_pkg::*;

    rbr_cmd_t cmd;
    rbr_sts_t sts;

    rbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbr_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

/* hw/rtl/rbr_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module rbr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              m_tready,
    input  wire rbr_pkg::rbr_sts_t sts,
    output rbr_pkg::rbr_cmd_t      cmd
);
    import rbr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                // The result register must be free or emptying this cycle.
                if (!sts.out_valid || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/rbr_datapath.sv */
// Datapath: configuration, backoff state, slot selection and result register.
`timescale 1ns / 1ps
`default_nettype none

module rbr_datapath #(
    parameter int SLOT_COUNT = rbr_pkg::SLOT_COUNT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [rbr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [rbr_pkg::DELAY_W-1:0]         cfg_wdata,
    input  wire logic [rbr_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [rbr_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire rbr_pkg::rbr_cmd_t                   cmd,
    output rbr_pkg::rbr_sts_t                        sts
);
    import rbr_pkg::*;

    localparam logic [MASK_W-1:0] SLOT_SEL_MASK =
        (SLOT_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SLOT_COUNT) - 1);

    // Configuration registers.
    logic [MASK_W-1:0]  slot_mask_reg;
    logic [DELAY_W-1:0] min_delay_reg;
    logic [DELAY_W-1:0] max_delay_reg;

    // Captured item.
    logic               en_reg;
    logic               up_reg;
    logic [TIME_W-1:0]  now_reg;

    // Backoff state.
    logic               was_linked_reg;
    logic [TIME_W-1:0]  last_attempt_reg;
    logic [DELAY_W-1:0] retry_delay_reg;
    logic [COUNT_W-1:0] rot_count_reg;
    logic [1:0]         rot_mod3_reg;

    // Evaluation results.
    logic               due_reg;
    logic               has_slot_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [DELAY_W-1:0] delay_dbl_reg;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [MASK_W-1:0]  present;
    logic [2:0]         slot_num;
    logic [SLOT_W-1:0]  pick;
    logic [SLOT_W-1:0]  pick_slot;
    logic [2:0]         seen;
    logic               found;
    logic [TIME_W-1:0]  elapsed;
    logic               due;
    logic [DELAY_W:0]   doubled;
    logic [DELAY_W-1:0] delay_dbl;
    logic               changed;
    logic               started;
    logic               no_cred;
    logic [1:0]         mod3_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_mask_reg <= SLOT_MASK_RST;
            min_delay_reg <= MIN_DELAY_RST;
            max_delay_reg <= MAX_DELAY_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SLOT_MASK: slot_mask_reg <= cfg_wdata[MASK_W-1:0];
                REG_MIN_DELAY: min_delay_reg <= cfg_wdata;
                REG_MAX_DELAY: max_delay_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            en_reg  <= s_tdata[0];
            up_reg  <= s_tdata[1];
            now_reg <= s_tdata[TIME_W+1:2];
        end
    end

    // Present slots, their number and the rotation index modulo that number.
    always_comb begin
        present  = slot_mask_reg & SLOT_SEL_MASK;
        slot_num = 3'(present[0]) + 3'(present[1]) + 3'(present[2]) + 3'(present[3]);
        case (slot_num)
            3'd2:    pick = {1'b0, rot_count_reg[0]};
            3'd3:    pick = rot_mod3_reg;
            3'd4:    pick = rot_count_reg[1:0];
            default: pick = '0;
        endcase
    end

    always_comb begin
        seen      = '0;
        found     = 1'b0;
        pick_slot = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (present[i] && !found) begin
                if (seen[SLOT_W-1:0] == pick) begin
                    pick_slot = SLOT_W'(i);
                    found     = 1'b1;
                end
                seen = seen + 3'd1;
            end
        end
    end

    always_comb begin
        elapsed   = now_reg - last_attempt_reg;
        due       = en_reg && !up_reg &&
                    ((last_attempt_reg == '0) || (elapsed >= {1'b0, retry_delay_reg}));
        doubled   = {retry_delay_reg, 1'b0};
        delay_dbl = (doubled > {1'b0, max_delay_reg}) ? max_delay_reg
                                                     : doubled[DELAY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            due_reg       <= due;
            has_slot_reg  <= (slot_num != 3'd0);
            slot_reg      <= pick_slot;
            delay_dbl_reg <= delay_dbl;
        end
    end

    // The residue modulo three restarts when the counter wraps to zero.
    always_comb begin
        if (rot_count_reg == {COUNT_W{1'b1}}) begin
            mod3_next = 2'd0;
        end else if (rot_mod3_reg == 2'd2) begin
            mod3_next = 2'd0;
        end else begin
            mod3_next = rot_mod3_reg + 2'd1;
        end
        changed = en_reg && (up_reg != was_linked_reg);
        started = due_reg && has_slot_reg;
        no_cred = due_reg && !has_slot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            was_linked_reg   <= 1'b0;
            last_attempt_reg <= '0;
            retry_delay_reg  <= MIN_DELAY_RST;
            rot_count_reg    <= '0;
            rot_mod3_reg     <= '0;
        end else if (cmd.commit && en_reg) begin
            was_linked_reg <= up_reg;
            if (up_reg) begin
                last_attempt_reg <= '0;
                retry_delay_reg  <= min_delay_reg;
                rot_count_reg    <= '0;
                rot_mod3_reg     <= '0;
            end else if (due_reg) begin
                last_attempt_reg <= now_reg;
                retry_delay_reg  <= delay_dbl_reg;
                if (has_slot_reg) begin
                    rot_count_reg <= rot_count_reg + COUNT_W'(1);
                    rot_mod3_reg  <= mod3_next;
                end
            end
        end
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_data_reg <= {2'b00, no_cred,
                             started ? slot_reg : {SLOT_W{1'b0}},
                             started,
                             en_reg ? up_reg : was_linked_reg,
                             changed};
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign sts.out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/rbr_checker.sv */
// Port-level checker for the reconnect backoff rotator and its bind.
`timescale 1ns / 1ps
`default_nettype none

module rbr_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rbr_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rbr_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_start_xor_nocred: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[5]))
        else $error("attempt started and no credentials in one item");

    a_start_link_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2] || m_tdata[5]) |-> !m_tdata[1])
        else $error("retry reported while link is up");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[4:3] == 2'b00)
        else $error("slot reported without an attempt");

endmodule

bind reconnect_backoff_rotator rbr_checker u_rbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
